/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LGSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lgss check failed");
`define LGSS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lgss forbidden condition");
`else
`define LGSS_ASSERT(lbl, prop)
`define LGSS_NEVER(lbl, expr)
`endif
`endif

/* hdl/lgss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_pkg
// Shared constants, codes and types of the landmark seed selection unit.
// ----------------------------------------------------------------------------
package lgss_pkg;

  localparam int MAX_HUBS      = 64;
  localparam int MAX_LANDMARKS = 16;
  localparam int DIST_BITS     = 16;
  localparam int HUB_W         = $clog2(MAX_HUBS);
  localparam int LMK_W         = $clog2(MAX_LANDMARKS);
  localparam int CNT_W         = HUB_W + 1;
  localparam int LCNT_W        = LMK_W + 1;
  localparam int SUM_W         = DIST_BITS + 1;
  localparam int TOT_W         = SUM_W + HUB_W;
  localparam int NODE_W        = 31;

  typedef enum logic [1:0] {
    FUNC_WR_DIST = 2'd0,
    FUNC_WR_NODE = 2'd1,
    FUNC_RUN     = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_SEED   = 2'd0,
    STATUS_PARTS  = 2'd1,
    STATUS_NOPAIR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_PARTS = 2'd0,
    CFG_HUBS  = 2'd1,
    CFG_LMKS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  parts;
    logic [CNT_W-1:0]  hubs;
    logic [LCNT_W-1:0] lmks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [LMK_W-1:0]     landmark_slot;
    logic [HUB_W-1:0]     hub_slot;
    logic [DIST_BITS-1:0] hop_distance;
    logic                 reachable;
    logic [NODE_W-1:0]    node_ident;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] seed_node;
    logic [HUB_W-1:0]  seed_hub;
    logic [HUB_W-1:0]  seed_order;
    logic [1:0]        status;
    logic              stopped_early;
    logic              last_result;
  } res_t;

endpackage

/* hdl/lgss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface lgss_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [lgss_pkg::LMK_W-1:0]     landmark_slot;
  logic [lgss_pkg::HUB_W-1:0]     hub_slot;
  logic [lgss_pkg::DIST_BITS-1:0] hop_distance;
  logic                           reachable;
  logic [lgss_pkg::NODE_W-1:0]    node_ident;
  modport source (output valid, func, landmark_slot, hub_slot, hop_distance, reachable,
                  node_ident, input ready);
  modport sink (input valid, func, landmark_slot, hub_slot, hop_distance, reachable,
                node_ident, output ready);
endinterface

interface lgss_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgss_pkg::NODE_W-1:0] seed_node;
  logic [lgss_pkg::HUB_W-1:0]  seed_hub;
  logic [lgss_pkg::HUB_W-1:0]  seed_order;
  logic [1:0]                  status;
  logic                        stopped_early;
  logic                        last_result;
  modport source (output valid, seed_node, seed_hub, seed_order, status, stopped_early,
                  last_result, input ready);
  modport sink (input valid, seed_node, seed_hub, seed_order, status, stopped_early,
                last_result, output ready);
endinterface

interface lgss_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [lgss_pkg::CNT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lgss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lgss_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/lgss_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lgss_core
// Table storage and the sequencer for the pair-table and greedy steps.
// ----------------------------------------------------------------------------
module lgss_core (
  input  logic            clk,
  input  logic            rst_n,
  input  lgss_pkg::cfg_t  cfg,
  input  logic            in_fire,
  input  lgss_pkg::item_t in_item,
  output logic            in_rdy,
  output logic            res_valid,
  input  logic            res_ready,
  output lgss_pkg::res_t  res
);
  import lgss_pkg::*;

  typedef enum logic [16:0] {
    S_CLR  = 17'b0_0000_0000_0000_0001,
    S_IDLE = 17'b0_0000_0000_0000_0010,
    S_ERR  = 17'b0_0000_0000_0000_0100,
    S_PA   = 17'b0_0000_0000_0000_1000,
    S_PB   = 17'b0_0000_0000_0001_0000,
    S_PC   = 17'b0_0000_0000_0010_0000,
    S_CH0  = 17'b0_0000_0000_0100_0000,
    S_CH1  = 17'b0_0000_0000_1000_0000,
    S_GI   = 17'b0_0000_0001_0000_0000,
    S_GC   = 17'b0_0000_0010_0000_0000,
    S_GP   = 17'b0_0000_0100_0000_0000,
    S_GS   = 17'b0_0000_1000_0000_0000,
    S_GE   = 17'b0_0001_0000_0000_0000,
    S_GW   = 17'b0_0010_0000_0000_0000,
    S_OC   = 17'b0_0100_0000_0000_0000,
    S_OV   = 17'b0_1000_0000_0000_0000,
    S_ON   = 17'b1_0000_0000_0000_0000
  } state_t;

  localparam int LH_AW = LMK_W + HUB_W;

  state_t               state_r, state_nxt;
  logic [LH_AW-1:0]     clr_r, clr_nxt;
  logic [HUB_W-1:0]     i_r, i_nxt, j_r, j_nxt, m_r, m_nxt, k_r, k_nxt;
  logic [LMK_W-1:0]     lm_r, lm_nxt;
  logic [DIST_BITS:0]   a_r, a_nxt;
  logic [SUM_W-1:0]     dmin_r, dmin_nxt, best_r, best_nxt;
  logic                 dok_r, dok_nxt;
  logic [HUB_W-1:0]     bi_r, bi_nxt, bj_r, bj_nxt, cand_r, cand_nxt, c_r, c_nxt;
  logic [MAX_HUBS-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TOT_W-1:0]     tot_r, tot_nxt, top_r, top_nxt;
  logic                 tval_r, tval_nxt, fnd_r, fnd_nxt, early_r, early_nxt;
  logic [1:0]           err_r, err_nxt;

  logic [CNT_W-1:0]     h_w;
  logic [LCNT_W-1:0]    l_w;
  logic [HUB_W-1:0]     hm1;
  logic [LMK_W-1:0]     lm1;

  logic                 lh_we;
  logic [LH_AW-1:0]     lh_waddr, lh_raddr;
  logic [DIST_BITS:0]   lh_wdata, lh_q, b_q;
  logic                 pr_we;
  logic [2*HUB_W-1:0]   pr_waddr, pr_raddr;
  logic [SUM_W:0]       pr_wdata, pr_q;
  logic                 ch_we;
  logic [HUB_W-1:0]     ch_waddr, ch_wdata, ch_raddr, ch_q;
  logic                 nd_we;
  logic [NODE_W-1:0]    nd_q;

  logic [SUM_W-1:0]     sum_w, nmin_w;
  logic                 both_w, nok_w, upd_w, pick_w, fnd_w;
  logic [HUB_W-1:0]     lo_w, hi_w;
  logic [CNT_W-1:0]     cnt_inc;

  assign h_w = (cfg.hubs > CNT_W'(MAX_HUBS)) ? CNT_W'(MAX_HUBS) : cfg.hubs;
  assign l_w = (cfg.lmks > LCNT_W'(MAX_LANDMARKS)) ? LCNT_W'(MAX_LANDMARKS) : cfg.lmks;
  assign hm1 = HUB_W'(h_w - CNT_W'(1));
  assign lm1 = LMK_W'(l_w - LCNT_W'(1));

  assign lh_we    = (state_r == S_CLR) ||
                    ((state_r == S_IDLE) && in_fire && (in_item.func == FUNC_WR_DIST));
  assign lh_waddr = (state_r == S_CLR) ? clr_r : {in_item.landmark_slot, in_item.hub_slot};
  assign lh_wdata = (state_r == S_CLR) ? '0 : {in_item.reachable, in_item.hop_distance};
  assign lh_raddr = (state_r == S_PA) ? {lm_r, i_r} : {lm_r, j_r};

  assign b_q    = lh_q;
  assign both_w = a_r[DIST_BITS] & b_q[DIST_BITS];
  assign sum_w  = SUM_W'(a_r[DIST_BITS-1:0]) + SUM_W'(b_q[DIST_BITS-1:0]);
  assign upd_w  = both_w && (!dok_r || (sum_w < dmin_r));
  assign nmin_w = upd_w ? sum_w : dmin_r;
  assign nok_w  = dok_r | both_w;

  assign pr_we    = (state_r == S_PC) && (lm_r == lm1);
  assign pr_waddr = {i_r, j_r};
  assign pr_wdata = {nok_w, nmin_w};
  assign lo_w     = (i_r < ch_q) ? i_r : ch_q;
  assign hi_w     = (i_r < ch_q) ? ch_q : i_r;
  assign pr_raddr = {lo_w, hi_w};

  assign ch_we    = (state_r == S_CH0) || (state_r == S_CH1) || (state_r == S_GW);
  assign ch_waddr = (state_r == S_CH0) ? HUB_W'(0) :
                    (state_r == S_CH1) ? HUB_W'(1) : cnt_r[HUB_W-1:0];
  assign ch_wdata = (state_r == S_CH0) ? bi_r : (state_r == S_CH1) ? bj_r : cand_r;
  assign ch_raddr = ((state_r == S_OC) || (state_r == S_ON) || (state_r == S_OV)) ?
                    k_r : m_r;

  assign nd_we = (state_r == S_IDLE) && in_fire && (in_item.func == FUNC_WR_NODE);

  assign pick_w  = tval_r && (!fnd_r || (tot_r > top_r));
  assign fnd_w   = (state_r == S_GE) ? (fnd_r | pick_w) : fnd_r;
  assign cnt_inc = cnt_r + CNT_W'(1);

  lgss_ram #(.AW(LH_AW), .DW(DIST_BITS + 1)) u_lh_ram (
    .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata), .raddr(lh_raddr), .rdata(lh_q)
  );
  lgss_ram #(.AW(2 * HUB_W), .DW(SUM_W + 1)) u_pair_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata), .raddr(pr_raddr), .rdata(pr_q)
  );
  lgss_ram #(.AW(HUB_W), .DW(HUB_W)) u_chosen_ram (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata), .raddr(ch_raddr), .rdata(ch_q)
  );
  lgss_ram #(.AW(HUB_W), .DW(NODE_W)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(in_item.hub_slot), .wdata(in_item.node_ident),
    .raddr(ch_q), .rdata(nd_q)
  );

  assign in_rdy    = (state_r == S_IDLE);
  assign res_valid = (state_r == S_ERR) || (state_r == S_OV);

  always_comb begin
    res = '0;
    if (state_r == S_ERR) begin
      res.status      = err_r;
      res.last_result = 1'b1;
    end else begin
      res.seed_node     = nd_q;
      res.seed_hub      = ch_q;
      res.seed_order    = k_r;
      res.status        = STATUS_SEED;
      res.stopped_early = early_r;
      res.last_result   = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    lm_nxt    = lm_r;
    a_nxt     = a_r;
    dmin_nxt  = dmin_r;
    dok_nxt   = dok_r;
    best_nxt  = best_r;
    bi_nxt    = bi_r;
    bj_nxt    = bj_r;
    cand_nxt  = cand_r;
    c_nxt     = c_r;
    used_nxt  = used_r;
    cnt_nxt   = cnt_r;
    tot_nxt   = tot_r;
    top_nxt   = top_r;
    tval_nxt  = tval_r;
    fnd_nxt   = fnd_r;
    early_nxt = early_r;
    err_nxt   = err_r;
    unique case (state_r) inside
      S_CLR: begin
        clr_nxt = clr_r + LH_AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && (in_item.func == FUNC_RUN)) begin
          if (cfg.parts > h_w) begin
            err_nxt   = STATUS_PARTS;
            state_nxt = S_ERR;
          end else if ((l_w == '0) || (h_w < CNT_W'(2))) begin
            err_nxt   = STATUS_NOPAIR;
            state_nxt = S_ERR;
          end else begin
            i_nxt     = '0;
            j_nxt     = HUB_W'(1);
            lm_nxt    = '0;
            dok_nxt   = 1'b0;
            dmin_nxt  = '0;
            best_nxt  = '0;
            bi_nxt    = '0;
            bj_nxt    = '0;
            early_nxt = 1'b0;
            state_nxt = S_PA;
          end
        end
      end
      S_ERR: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_PA: state_nxt = S_PB;
      S_PB: begin
        a_nxt     = lh_q;
        state_nxt = S_PC;
      end
      S_PC: begin
        if (lm_r == lm1) begin
          if (nok_w && (nmin_w > best_r)) begin
            best_nxt = nmin_w;
            bi_nxt   = i_r;
            bj_nxt   = j_r;
          end
          dok_nxt  = 1'b0;
          dmin_nxt = '0;
          lm_nxt   = '0;
          if (j_r == hm1) begin
            if (i_r == HUB_W'(hm1 - HUB_W'(1))) begin
              state_nxt = S_CH0;
            end else begin
              i_nxt     = i_r + HUB_W'(1);
              j_nxt     = i_r + HUB_W'(2);
              state_nxt = S_PA;
            end
          end else begin
            j_nxt     = j_r + HUB_W'(1);
            state_nxt = S_PA;
          end
        end else begin
          dok_nxt   = nok_w;
          dmin_nxt  = nmin_w;
          lm_nxt    = lm_r + LMK_W'(1);
          state_nxt = S_PA;
        end
      end
      S_CH0: begin
        used_nxt         = '0;
        used_nxt[bi_r]   = 1'b1;
        state_nxt        = S_CH1;
      end
      S_CH1: begin
        used_nxt[bj_r] = 1'b1;
        cnt_nxt        = CNT_W'(2);
        i_nxt          = '0;
        m_nxt          = '0;
        tot_nxt        = '0;
        tval_nxt       = 1'b1;
        fnd_nxt        = 1'b0;
        k_nxt          = '0;
        state_nxt      = (cfg.parts > CNT_W'(2)) ? S_GI : S_OC;
      end
      S_GI, S_GE: begin
        if ((state_r == S_GE) && pick_w) begin
          top_nxt  = tot_r;
          cand_nxt = i_r;
        end
        fnd_nxt = fnd_w;
        if ((state_r == S_GI) && !used_r[i_r]) begin
          m_nxt     = '0;
          tot_nxt   = '0;
          tval_nxt  = 1'b1;
          state_nxt = S_GC;
        end else if (i_r == hm1) begin
          if (fnd_w) begin
            state_nxt = S_GW;
          end else begin
            early_nxt = 1'b1;
            k_nxt     = '0;
            state_nxt = S_OC;
          end
        end else begin
          i_nxt     = i_r + HUB_W'(1);
          state_nxt = S_GI;
        end
      end
      S_GC: state_nxt = S_GP;
      S_GP: begin
        c_nxt     = ch_q;
        state_nxt = S_GS;
      end
      S_GS: begin
        if (i_r == c_r) begin
          if ((CNT_W'(m_r) + CNT_W'(1)) == cnt_r) begin
            state_nxt = S_GE;
          end else begin
            m_nxt     = m_r + HUB_W'(1);
            state_nxt = S_GC;
          end
        end else if (!pr_q[SUM_W]) begin
          tval_nxt  = 1'b0;
          state_nxt = S_GE;
        end else begin
          tot_nxt = tot_r + TOT_W'(pr_q[SUM_W-1:0]);
          if ((CNT_W'(m_r) + CNT_W'(1)) == cnt_r) begin
            state_nxt = S_GE;
          end else begin
            m_nxt     = m_r + HUB_W'(1);
            state_nxt = S_GC;
          end
        end
      end
      S_GW: begin
        used_nxt[cand_r] = 1'b1;
        cnt_nxt          = cnt_inc;
        i_nxt            = '0;
        fnd_nxt          = 1'b0;
        k_nxt            = '0;
        if ((cnt_inc < cfg.parts) && (cnt_inc < CNT_W'(MAX_HUBS))) begin
          state_nxt = S_GI;
        end else begin
          state_nxt = S_OC;
        end
      end
      S_OC: state_nxt = S_ON;
      S_ON: state_nxt = S_OV;
      S_OV: begin
        if (res_ready) begin
          if (res.last_result) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + HUB_W'(1);
            state_nxt = S_OC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      used_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    m_r     <= m_nxt;
    k_r     <= k_nxt;
    lm_r    <= lm_nxt;
    a_r     <= a_nxt;
    dmin_r  <= dmin_nxt;
    dok_r   <= dok_nxt;
    best_r  <= best_nxt;
    bi_r    <= bi_nxt;
    bj_r    <= bj_nxt;
    cand_r  <= cand_nxt;
    c_r     <= c_nxt;
    tot_r   <= tot_nxt;
    top_r   <= top_nxt;
    tval_r  <= tval_nxt;
    fnd_r   <= fnd_nxt;
    early_r <= early_nxt;
    err_r   <= err_nxt;
  end

  `LGSS_ASSERT(a_cnt_max, (cnt_r <= CNT_W'(MAX_HUBS)))
  `LGSS_ASSERT(a_greedy_cnt, ((state_r == S_GI || state_r == S_GW) |-> cnt_r >= CNT_W'(2)))
  `LGSS_ASSERT(a_used_cnt, (state_r == S_OV |-> $countones(used_r) <= 32'(cnt_r)))
  `LGSS_NEVER(a_ready_result, (in_rdy && res_valid))
endmodule

/* hdl/landmark_greedy_seed_select_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_greedy_seed_select_unit
// Greedy max-sum dispersion seed selection over landmark-estimated hub pairs.
// ----------------------------------------------------------------------------
// Distance and node id writes are accepted back to back. After reset the
// landmark table is swept to unreachable entry by entry, during which no
// item is taken. A run item holds the input for its whole length: the pair
// table is built over all H*(H-1)/2 hub pairs, one landmark at a time; each
// greedy round visits every unused hub and sums its pair distances to the
// seeds chosen so far, skipping used hubs; then the seed results go out one
// by one. All of it is paced by the single read port of each table.
module landmark_greedy_seed_select_unit (
  input  logic        clk,
  input  logic        rst_n,
  lgss_in_if.sink     in_ch,
  lgss_out_if.source  out_ch,
  lgss_cfg_if.sink    cfg_ch
);
  import lgss_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t item_w;
  res_t  res_w, out_r;
  logic  out_v_r, out_v_nxt;
  logic  res_valid, res_ready, in_rdy;

  assign item_w = '{func: in_ch.func, landmark_slot: in_ch.landmark_slot,
                    hub_slot: in_ch.hub_slot, hop_distance: in_ch.hop_distance,
                    reachable: in_ch.reachable, node_ident: in_ch.node_ident};

  lgss_core u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_fire(in_ch.valid && in_rdy), .in_item(item_w), .in_rdy(in_rdy),
    .res_valid(res_valid), .res_ready(res_ready), .res(res_w)
  );

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign res_ready    = !out_v_r || out_ch.ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PARTS: cfg_nxt.parts = cfg_ch.data;
        CFG_HUBS:  cfg_nxt.hubs  = cfg_ch.data;
        CFG_LMKS:  cfg_nxt.lmks  = cfg_ch.data[LCNT_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_v_nxt = res_valid || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{parts: CNT_W'(2), hubs: '0, lmks: '0};
      out_v_r <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res_w;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.seed_node     = out_r.seed_node;
  assign out_ch.seed_hub      = out_r.seed_hub;
  assign out_ch.seed_order    = out_r.seed_order;
  assign out_ch.status        = out_r.status;
  assign out_ch.stopped_early = out_r.stopped_early;
  assign out_ch.last_result   = out_r.last_result;
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the landmark seed selection unit. It loads the
// landmark and hub tables, runs selections over a range of register settings
// and compares every seed against a local greedy selection of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import lgss_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;

  lgss_in_if  in_ch ();
  lgss_out_if out_ch ();
  lgss_cfg_if cfg_ch ();

  landmark_greedy_seed_select_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // model state
  int unsigned hop_tab [MAX_LANDMARKS][MAX_HUBS];
  bit          reach_tab [MAX_LANDMARKS][MAX_HUBS];
  logic [NODE_W-1:0] node_tab [MAX_HUBS];
  bit          node_known [MAX_HUBS];
  int unsigned parts_reg, hubs_reg, lmks_reg;
  res_t        seed_q [$];

  int unsigned errors, cycles, item_count;
  int unsigned src_idle, snk_stall;
  int unsigned hold_req, hold_seen, hold_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sink side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // compare each result transfer with the oldest expected seed
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (seed_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = seed_q.pop_front();
        if (out_ch.seed_node !== exp_r.seed_node) begin
          $error("seed_node exp %0d got %0d", exp_r.seed_node, out_ch.seed_node);
          errors++;
        end
        if (out_ch.seed_hub !== exp_r.seed_hub) begin
          $error("seed_hub exp %0d got %0d", exp_r.seed_hub, out_ch.seed_hub);
          errors++;
        end
        if (out_ch.seed_order !== exp_r.seed_order) begin
          $error("seed_order exp %0d got %0d", exp_r.seed_order, out_ch.seed_order);
          errors++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_ch.status);
          errors++;
        end
        if (out_ch.stopped_early !== exp_r.stopped_early) begin
          $error("stopped_early exp %0b got %0b", exp_r.stopped_early, out_ch.stopped_early);
          errors++;
        end
        if (out_ch.last_result !== exp_r.last_result) begin
          $error("last_result exp %0b got %0b", exp_r.last_result, out_ch.last_result);
          errors++;
        end
      end
    end
  end

  function automatic bit pair_dist(int a, int b, ref int unsigned pv [MAX_HUBS][MAX_HUBS],
                                   ref bit pok [MAX_HUBS][MAX_HUBS], output int unsigned v);
    if (a == b) begin
      v = 0;
      return 1'b1;
    end
    v = pv[a][b];
    return pok[a][b];
  endfunction

  function automatic void add_expected(int unsigned hub, int unsigned order, status_t st,
                                       bit early, bit last);
    res_t r;
    r.seed_node     = (st == STATUS_SEED) ? node_tab[hub] : '0;
    r.seed_hub      = hub[HUB_W-1:0];
    r.seed_order    = order[HUB_W-1:0];
    r.status        = st;
    r.stopped_early = early;
    r.last_result   = last;
    seed_q = {seed_q, r};
  endfunction

  // greedy max-sum dispersion selection over landmark pair estimates
  function automatic void select_seeds();
    int unsigned pv [MAX_HUBS][MAX_HUBS];
    bit          pok [MAX_HUBS][MAX_HUBS];
    int unsigned h, l, s, mn, v, total, cand, cnt;
    int unsigned picks [MAX_HUBS];
    bit          taken [MAX_HUBS];
    longint      best, top;
    bit          ok, valid, found, early;
    h = (hubs_reg > MAX_HUBS) ? MAX_HUBS : hubs_reg;
    l = (lmks_reg > MAX_LANDMARKS) ? MAX_LANDMARKS : lmks_reg;
    if (parts_reg > h) begin
      add_expected(0, 0, STATUS_PARTS, 1'b0, 1'b1);
      return;
    end
    if (l == 0 || h < 2) begin
      add_expected(0, 0, STATUS_NOPAIR, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < h; i++) begin
      for (int j = i + 1; j < h; j++) begin
        ok = 1'b0;
        mn = 0;
        for (int m = 0; m < l; m++) begin
          if (reach_tab[m][i] && reach_tab[m][j]) begin
            s = hop_tab[m][i] + hop_tab[m][j];
            if (!ok || s < mn) begin
              mn = s;
              ok = 1'b1;
            end
          end
        end
        pv[i][j] = mn; pv[j][i] = mn;
        pok[i][j] = ok; pok[j][i] = ok;
      end
    end
    best = -1;
    picks[0] = 0; picks[1] = 0;
    for (int i = 0; i < h; i++) begin
      for (int j = 0; j < h; j++) begin
        if (pair_dist(i, j, pv, pok, v) && longint'(v) > best) begin
          best = v; picks[0] = i; picks[1] = j;
        end
      end
    end
    foreach (taken[i]) taken[i] = 1'b0;
    taken[picks[0]] = 1'b1;
    taken[picks[1]] = 1'b1;
    cnt = 2;
    early = 1'b0;
    for (int k = 2; k < parts_reg && cnt < MAX_HUBS; k++) begin
      top = -1;
      cand = 0;
      found = 1'b0;
      for (int i = 0; i < h; i++) begin
        if (!taken[i]) begin
          total = 0;
          valid = 1'b1;
          for (int m = 0; m < cnt; m++) begin
            if (!pair_dist(i, picks[m], pv, pok, v)) begin
              valid = 1'b0;
              break;
            end
            total += v;
          end
          if (valid && longint'(total) > top) begin
            top = total; cand = i; found = 1'b1;
          end
        end
      end
      if (!found) begin
        early = 1'b1;
        break;
      end
      picks[cnt] = cand;
      taken[cand] = 1'b1;
      cnt++;
    end
    for (int k = 0; k < cnt; k++) add_expected(picks[k], k, STATUS_SEED, early, k + 1 == cnt);
  endfunction

  function automatic void apply_item(item_t it);
    case (func_t'(it.func))
      FUNC_WR_DIST: begin
        hop_tab[it.landmark_slot][it.hub_slot]   = 32'(it.hop_distance);
        reach_tab[it.landmark_slot][it.hub_slot] = it.reachable;
      end
      FUNC_WR_NODE: begin
        node_tab[it.hub_slot]   = it.node_ident;
        node_known[it.hub_slot] = 1'b1;
      end
      FUNC_RUN: select_seeds();
      default: ;
    endcase
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= it.func;
    in_ch.landmark_slot <= it.landmark_slot;
    in_ch.hub_slot      <= it.hub_slot;
    in_ch.hop_distance  <= it.hop_distance;
    in_ch.reachable     <= it.reachable;
    in_ch.node_ident    <= it.node_ident;
    do @(posedge clk); while (!in_ch.ready);
    item_count++;
    apply_item(it);
  endtask

  task automatic send_dist(int unsigned lm, int unsigned hub, int unsigned d, bit ok);
    item_t it;
    it = '{func: FUNC_WR_DIST, landmark_slot: LMK_W'(lm), hub_slot: HUB_W'(hub),
           hop_distance: DIST_BITS'(d), reachable: ok, node_ident: NODE_W'($urandom())};
    send_item(it);
  endtask

  task automatic send_node(int unsigned hub, int unsigned id);
    item_t it;
    it = '{func: FUNC_WR_NODE, landmark_slot: LMK_W'($urandom()), hub_slot: HUB_W'(hub),
           hop_distance: DIST_BITS'($urandom()), reachable: 1'($urandom()),
           node_ident: NODE_W'(id)};
    send_item(it);
  endtask

  task automatic send_cmd(func_t f);
    item_t it;
    it = '{func: f, landmark_slot: LMK_W'($urandom()), hub_slot: HUB_W'($urandom()),
           hop_distance: DIST_BITS'($urandom()), reachable: 1'($urandom()),
           node_ident: NODE_W'($urandom())};
    send_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (seed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_PARTS: parts_reg = val & 127;
      CFG_HUBS:  hubs_reg  = val & 127;
      default:   lmks_reg  = val & 31;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned parts, int unsigned hubs, int unsigned lmks);
    drain();
    write_reg(CFG_PARTS, parts);
    write_reg(CFG_HUBS, hubs);
    write_reg(CFG_LMKS, lmks);
  endtask

  task automatic fill_nodes(int unsigned h);
    for (int i = 0; i < h && i < MAX_HUBS; i++)
      if (!node_known[i]) send_node(i, $urandom() & 32'h7fffffff);
  endtask

  task automatic test_error_cases();
    set_regs(3, 2, 0);
    send_cmd(FUNC_RUN);
    set_regs(2, 2, 0);
    send_cmd(FUNC_RUN);
    set_regs(1, 1, 1);
    send_cmd(FUNC_RUN);
    set_regs(100, 127, 31);
    send_cmd(FUNC_RUN);
  endtask

  task automatic test_unreachable_pairs();
    set_regs(3, 3, 1);
    send_node(0, 32'h7fffffff);
    send_node(1, 0);
    send_node(2, 32'h2aaaaaaa);
    send_cmd(FUNC_NONE);
    send_cmd(FUNC_RUN);
  endtask

  task automatic test_extremes();
    set_regs(0, 4, 2);
    fill_nodes(4);
    send_dist(15, 63, 65534, 1'b1);
    send_node(63, 32'h55555555);
    send_dist(0, 0, 0, 1'b1);
    send_dist(0, 3, 65534, 1'b1);
    send_dist(1, 1, 65534, 1'b1);
    send_dist(1, 2, 1, 1'b1);
    send_dist(0, 2, 7, 1'b0);
    send_cmd(FUNC_RUN);
    set_regs(4, 4, 2);
    send_cmd(FUNC_RUN);
  endtask

  // all 64 hubs in use, only the low eight ever reachable
  task automatic test_full_size();
    set_regs(64, 127, 31);
    fill_nodes(8);
    for (int n = 0; n < 10; n++)
      send_dist($urandom_range(15), $urandom_range(7), $urandom_range(65534), 1'b1);
    send_cmd(FUNC_RUN);
    set_regs(64, 64, 16);
    for (int m = 0; m < 4; m++) send_dist(m, $urandom_range(7), $urandom_range(9), 1'b1);
    send_cmd(FUNC_RUN);
  endtask

  task automatic test_back_pressure();
    set_regs(6, 6, 2);
    fill_nodes(6);
    for (int i = 0; i < 6; i++) send_dist(0, i, $urandom_range(50), 1'b1);
    hold_req++;
    send_cmd(FUNC_RUN);
    for (int n = 0; n < 6; n++) send_dist(1, $urandom_range(5), $urandom_range(50), 1'b1);
    send_cmd(FUNC_RUN);
    drain();
  endtask

  task automatic test_random();
    int unsigned h, l, n;
    while (item_count < 110) begin
      h = $urandom_range(2, 8);
      l = $urandom_range(1, 4);
      set_regs($urandom_range(0, h + 1), h, l);
      fill_nodes(h);
      n = $urandom_range(3, 10);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(9))
          0: send_dist($urandom_range(15), $urandom_range(63), $urandom_range(65534),
                       1'($urandom()));
          1: send_cmd(FUNC_NONE);
          2: send_node($urandom_range(63), $urandom() & 32'h7fffffff);
          default: send_dist($urandom_range(l - 1), $urandom_range(h - 1),
                             $urandom_range(3) == 0 ? $urandom_range(65534)
                                                    : $urandom_range(40),
                             $urandom_range(4) != 0);
        endcase
      end
      send_cmd(FUNC_RUN);
      if ($urandom_range(3) == 0) send_cmd(FUNC_RUN);
    end
  endtask

  initial begin
    errors = 0; cycles = 0; item_count = 0;
    hold_req = 0; hold_seen = 0; hold_left = 0;
    src_idle = 0; snk_stall = 0;
    parts_reg = 2; hubs_reg = 0; lmks_reg = 0;
    foreach (reach_tab[m, i]) begin
      reach_tab[m][i] = 1'b0;
      hop_tab[m][i]   = 0;
    end
    foreach (node_known[i]) node_known[i] = 1'b0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_NONE;
    in_ch.landmark_slot <= '0;
    in_ch.hub_slot      <= '0;
    in_ch.hop_distance  <= '0;
    in_ch.reachable     <= 1'b0;
    in_ch.node_ident    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_PARTS;
    cfg_ch.data         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle = 36; snk_stall = 55;
    test_error_cases();
    test_unreachable_pairs();
    test_full_size();
    src_idle = 55; snk_stall = 36;
    test_extremes();
    test_back_pressure();
    src_idle = 0; snk_stall = 0;
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
